// ===== rtl/oaat_pkg.sv =====
// Shared constants and types for the one-at-a-time hash bucket unit.
package oaat_pkg;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int BUCKET_W = 32;

  // Defaults for the top-level parameters
  localparam int HASH_WIDTH_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Reset value of the bucket count register
  localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = 32'd1;

  // Per-byte mix shifts
  localparam int MIX_SHL = 10;
  localparam int MIX_SHR = 6;

  // Finalization shifts
  localparam int FIN_SHL_A = 3;
  localparam int FIN_SHR   = 11;
  localparam int FIN_SHL_B = 15;

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FINAL,
    BK_DIVIDE,
    BK_DONE
  } bk_state_t;

endpackage

// ===== rtl/oaat_queue.sv =====
// Short register queue of unfinalized key hashes between front and back end.
module oaat_queue
  import oaat_pkg::*;
#(
  parameter int HASH_WIDTH  = HASH_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [HASH_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic [HASH_WIDTH-1:0] pop_data,
  output q_status_t             status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [HASH_WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  do_push;
  logic                  do_pop;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  // Store pushed hash
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue occupancy beyond depth");

endmodule

// ===== rtl/oaat_front.sv =====
// Front end: accepts key bytes, mixes them and queues the hash at each key end.
module oaat_front
  import oaat_pkg::*;
#(
  parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     key_byte,
  input  logic                  byte_present,
  input  logic                  key_end,
  input  q_status_t             q_status,
  output logic                  q_push,
  output logic [HASH_WIDTH-1:0] q_data
);

  logic [HASH_WIDTH-1:0] running_hash;
  logic [HASH_WIDTH-1:0] running_hash_next;
  logic [HASH_WIDTH-1:0] add_byte;
  logic [HASH_WIDTH-1:0] add_shl;
  logic [HASH_WIDTH-1:0] mixed;
  logic                  accept;

  // Hold off new transactions while the queue has no room
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Mix one byte: add byte, add shift-left, xor shift-right
  always_comb begin
    add_byte = running_hash + HASH_WIDTH'(key_byte);
    add_shl  = add_byte + (add_byte << MIX_SHL);
    mixed    = byte_present ? (add_shl ^ (add_shl >> MIX_SHR)) : running_hash;
  end

  assign q_push = accept && key_end;
  assign q_data = mixed;

  // Clear after a key end, otherwise keep the mixed value
  always_comb begin
    running_hash_next = running_hash;
    if (accept) begin
      running_hash_next = key_end ? '0 : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else begin
      running_hash <= running_hash_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    q_push |=> running_hash == '0)
    else $error("running hash not cleared after key end");

endmodule

// ===== rtl/oaat_back.sv =====
// Back end: finalizes a queued hash and reduces it modulo the bucket count.
module oaat_back
  import oaat_pkg::*;
#(
  parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [BUCKET_W-1:0]   bucket_count,
  input  q_status_t             q_status,
  input  logic [HASH_WIDTH-1:0] q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BUCKET_W-1:0]   bucket_index,
  output logic                  size_error
);

  localparam int CNT_W = $clog2(HASH_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_WIDTH - 1);

  bk_state_t             state;
  bk_state_t             state_next;
  logic [HASH_WIDTH-1:0] dividend;
  logic [BUCKET_W-1:0]   divisor;
  logic [BUCKET_W-1:0]   rem;
  logic                  err;
  logic [CNT_W-1:0]      cnt;
  logic                  out_load;
  logic                  out_free;

  logic [HASH_WIDTH-1:0] fin_a;
  logic [HASH_WIDTH-1:0] fin_b;
  logic [HASH_WIDTH-1:0] fin_c;
  logic [BUCKET_W:0]     trial;
  logic [BUCKET_W:0]     trial_sub;
  logic                  trial_ge;

  // Finalize: add shift-left, xor shift-right, add shift-left
  always_comb begin
    fin_a = dividend + (dividend << FIN_SHL_A);
    fin_b = fin_a ^ (fin_a >> FIN_SHR);
    fin_c = fin_b + (fin_b << FIN_SHL_B);
  end

  // One restoring division step per cycle
  always_comb begin
    trial     = {rem, dividend[HASH_WIDTH-1]};
    trial_ge  = (trial >= {1'b0, divisor});
    trial_sub = trial - {1'b0, divisor};
  end

  assign out_free = !out_valid || !out_stall;

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop      = 1'b1;
          state_next = BK_FINAL;
        end
      end
      BK_FINAL: begin
        state_next = (divisor == '0) ? BK_DONE : BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (cnt == CNT_LAST) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath for the finalize and divide steps
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        dividend <= q_data;
        divisor  <= bucket_count;
      end
      BK_FINAL: begin
        dividend <= fin_c;
        rem      <= '0;
        cnt      <= '0;
        err      <= (divisor == '0);
      end
      BK_DIVIDE: begin
        rem      <= trial_ge ? trial_sub[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
        dividend <= dividend << 1;
        cnt      <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bucket_index <= err ? '0 : rem;
      size_error   <= err;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIVIDE |-> rem < divisor)
    else $error("partial remainder not below divisor");

  a_error_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && size_error |-> bucket_index == '0)
    else $error("nonzero bucket index with size error");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == BK_IDLE && !q_status.empty)
    else $error("queue popped outside idle state");

endmodule

// ===== rtl/one_at_a_time_hash_bucket_unit.sv =====
// Top level of the one-at-a-time hash bucket unit.
//
// Key bytes enter one transaction per cycle while in_stall is low; each is mixed
// into a running hash in the cycle it is accepted. A transaction with key_end set
// hands the hash to a queue of QUEUE_DEPTH entries and clears the running hash.
// The back end takes one key at a time through its bit-serial modulo unit: one
// load, one finalize, HASH_WIDTH restoring divide steps and one output load, so
// short keys are limited by the divider and long keys by the byte stream. A
// bucket count of zero skips the divide and returns size_error with
// bucket_index 0. bucket_count resets to 1 and is written with cfg_wr_en.
module one_at_a_time_hash_bucket_unit
  import oaat_pkg::*;
#(
  parameter int HASH_WIDTH  = HASH_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [BUCKET_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   key_byte,
  input  logic                byte_present,
  input  logic                key_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BUCKET_W-1:0] bucket_index,
  output logic                size_error
);

  logic [BUCKET_W-1:0]   bucket_count;
  q_status_t             q_status;
  logic                  q_push;
  logic                  q_pop;
  logic [HASH_WIDTH-1:0] q_push_data;
  logic [HASH_WIDTH-1:0] q_pop_data;

  // Bucket count register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  oaat_front #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key_byte    (key_byte),
    .byte_present(byte_present),
    .key_end     (key_end),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  oaat_queue #(
    .HASH_WIDTH (HASH_WIDTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .status   (q_status)
  );

  oaat_back #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .bucket_count(bucket_count),
    .q_status    (q_status),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket_index(bucket_index),
    .size_error  (size_error)
  );

endmodule
